>>> design/bird_pkg.sv
// ----------------------------------------------------------------------------
// bird_pkg
// shared widths, register indexes, reset values and types of the beat
// interval rate detector
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bird_pkg;

    localparam int DEF_SAMPLE_BITS   = 16;
    localparam int DEF_INTERVAL_BITS = 16;
    localparam int DEF_QUEUE_DEPTH   = 4;

    localparam int THRESHOLD_W  = 30;
    localparam int HOLDOFF_W    = 8;
    localparam int RATE_W       = 10;
    localparam int MIN_RATE_W   = 8;
    localparam int BPM_W        = 16;
    localparam int CFG_INDEX_W  = 4;
    localparam int CFG_DATA_W   = THRESHOLD_W;

    localparam int SECONDS_PER_MINUTE = 60;

    localparam logic [THRESHOLD_W-1:0] RST_BEAT_THRESHOLD  = THRESHOLD_W'(300);
    localparam logic [HOLDOFF_W-1:0]   RST_HOLDOFF_SAMPLES = HOLDOFF_W'(60);
    localparam logic [RATE_W-1:0]      RST_SAMPLE_RATE     = RATE_W'(120);
    localparam logic [MIN_RATE_W-1:0]  RST_MIN_RATE        = MIN_RATE_W'(30);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BEAT_THRESHOLD  = CFG_INDEX_W'(0),
        CFG_HOLDOFF_SAMPLES = CFG_INDEX_W'(1),
        CFG_SAMPLE_RATE     = CFG_INDEX_W'(2),
        CFG_MIN_RATE        = CFG_INDEX_W'(3)
    } t_cfg_index;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

>>> design/bird_queue.sv
// ----------------------------------------------------------------------------
// bird_queue
// small fifo of beat intervals between the classifier and the divider
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bird_queue #(
    parameter int WIDTH = bird_pkg::DEF_INTERVAL_BITS,
    parameter int DEPTH = bird_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [WIDTH-1:0]      i_push_data,
    input  logic                  i_pop,
    output logic [WIDTH-1:0]      o_pop_data,
    output bird_pkg::t_queue_status o_status
);
    import bird_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_pop_data     = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.full |-> !i_push)
        else $error("interval pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.empty |-> !i_pop)
        else $error("interval popped from an empty queue");
`endif

endmodule

>>> design/bird_front.sv
// ----------------------------------------------------------------------------
// bird_front
// squares each sample, detects beats and queues the interval of every beat
// with a nonzero interval whose rate lies above the minimum
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bird_front #(
    parameter int SAMPLE_BITS   = bird_pkg::DEF_SAMPLE_BITS,
    parameter int INTERVAL_BITS = bird_pkg::DEF_INTERVAL_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [SAMPLE_BITS-1:0]      i_filtered_sample,
    input  logic [bird_pkg::THRESHOLD_W-1:0]   i_beat_threshold,
    input  logic [bird_pkg::HOLDOFF_W-1:0]     i_holdoff_samples,
    input  logic [bird_pkg::MIN_RATE_W-1:0]    i_min_rate,
    input  logic [bird_pkg::BPM_W-1:0]         i_rate_num,
    input  bird_pkg::t_queue_status            i_q_status,
    output logic                               o_push,
    output logic [INTERVAL_BITS-1:0]           o_push_interval
);
    import bird_pkg::*;

    localparam int SQ_W   = 2 * SAMPLE_BITS;
    localparam int CMP_W  = (SQ_W > THRESHOLD_W) ? SQ_W : THRESHOLD_W;
    localparam int PROD_W = MIN_RATE_W + INTERVAL_BITS;

    logic                     r_busy;
    logic [SQ_W-1:0]          r_sq;
    logic [HOLDOFF_W-1:0]     r_holdoff;
    logic [INTERVAL_BITS-1:0] r_interval;

    logic [SAMPLE_BITS-1:0]   mag;
    logic                     over;
    logic                     beat;
    logic                     emit;
    logic                     commit;
    logic                     accept;
    logic [PROD_W-1:0]        min_prod;
    logic [INTERVAL_BITS-1:0] interval_base;
    logic [HOLDOFF_W-1:0]     n_holdoff;
    logic [INTERVAL_BITS-1:0] n_interval;

    // most negative sample gives 2^(n-1), which still fits unsigned
    assign mag = i_filtered_sample[SAMPLE_BITS-1] ? (~i_filtered_sample + 1'b1)
                                                  : i_filtered_sample;

    assign over     = CMP_W'(r_sq) > CMP_W'(i_beat_threshold);
    assign beat     = over && (r_holdoff == '0);
    assign min_prod = PROD_W'(i_min_rate) * PROD_W'(r_interval);
    // exact rational test num / interval > min_rate
    assign emit     = beat && (r_interval != '0) && (PROD_W'(i_rate_num) > min_prod);

    assign commit   = r_busy && !(emit && i_q_status.full);
    assign o_stall  = r_busy && !commit;
    assign accept   = i_valid && !o_stall;

    assign o_push          = commit && emit;
    assign o_push_interval = r_interval;

    always_comb begin
        if (over) begin
            n_holdoff = i_holdoff_samples;
        end else if (r_holdoff != '0) begin
            n_holdoff = r_holdoff - 1'b1;
        end else begin
            n_holdoff = r_holdoff;
        end
        interval_base = beat ? INTERVAL_BITS'(1) : r_interval;
        n_interval    = (interval_base != '1) ? interval_base + 1'b1 : interval_base;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sq <= SQ_W'(mag) * SQ_W'(mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_holdoff  <= '0;
            r_interval <= '0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (commit) begin
                r_busy <= 1'b0;
            end
            if (commit) begin
                r_holdoff  <= n_holdoff;
                r_interval <= n_interval;
            end
        end
    end

endmodule

>>> design/bird_back.sv
// ----------------------------------------------------------------------------
// bird_back
// restoring divider that turns a queued interval into beats per minute,
// one quotient bit a cycle, with a registered output stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bird_back #(
    parameter int INTERVAL_BITS = bird_pkg::DEF_INTERVAL_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [bird_pkg::BPM_W-1:0]    i_rate_num,
    input  bird_pkg::t_queue_status       i_q_status,
    input  logic [INTERVAL_BITS-1:0]      i_q_interval,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [bird_pkg::BPM_W-1:0]    o_beats_per_minute
);
    import bird_pkg::*;

    localparam int STEP_W = $clog2(BPM_W);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                   r_state;
    t_state                   n_state;
    logic [INTERVAL_BITS-1:0] r_div;
    logic [INTERVAL_BITS-1:0] r_rem;
    logic [BPM_W-1:0]         r_quo;
    logic [STEP_W-1:0]        r_step;
    logic                     r_out_valid;
    logic [BPM_W-1:0]         r_out_bpm;

    logic [INTERVAL_BITS:0]   trial;
    logic                     fits;
    logic                     out_free;
    logic                     out_load;

    assign trial    = {r_rem, r_quo[BPM_W-1]};
    assign fits     = trial >= {1'b0, r_div};
    assign out_free = !r_out_valid || !i_stall;
    assign out_load = (r_state == S_DONE) && out_free;
    assign o_pop    = (r_state == S_IDLE) && !i_q_status.empty;

    assign o_valid            = r_out_valid;
    assign o_beats_per_minute = r_out_bpm;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_status.empty) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_step == STEP_W'(BPM_W - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_div <= i_q_interval;
            r_rem <= '0;
            r_quo <= i_rate_num;
        end else if (r_state == S_DIV) begin
            // dividend bits leave at the top, quotient bits enter at the bottom
            r_rem <= fits ? INTERVAL_BITS'(trial - {1'b0, r_div}) : INTERVAL_BITS'(trial);
            r_quo <= {r_quo[BPM_W-2:0], fits};
        end
        if (out_load) begin
            r_out_bpm <= r_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_step <= '0;
            end else if (r_state == S_DIV) begin
                r_step <= r_step + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (i_q_interval != '0))
        else $error("zero interval reached the divider");

    a_stalled_rate_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_beats_per_minute)))
        else $error("stalled rate changed or dropped");
`endif

endmodule

>>> design/beat_interval_rate_detector.sv
// ----------------------------------------------------------------------------
// beat_interval_rate_detector: squares samples, detects beats, emits rate
// a sample can be taken every cycle; the front stalls only when a beat to be
// queued finds the interval queue full
// a rate comes from the 16-step divider, which takes a new interval from the
// queue only after the last rate has been loaded into the output register
// synchronous reset clears counters, queue and divider; registers reload
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module beat_interval_rate_detector #(
    parameter int SAMPLE_BITS   = bird_pkg::DEF_SAMPLE_BITS,
    parameter int INTERVAL_BITS = bird_pkg::DEF_INTERVAL_BITS,
    parameter int QUEUE_DEPTH   = bird_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [SAMPLE_BITS-1:0]      i_filtered_sample,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [bird_pkg::BPM_W-1:0]         o_beats_per_minute,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bird_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [bird_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import bird_pkg::*;

    logic [THRESHOLD_W-1:0]   r_beat_threshold;
    logic [HOLDOFF_W-1:0]     r_holdoff_samples;
    logic [RATE_W-1:0]        r_sample_rate;
    logic [MIN_RATE_W-1:0]    r_min_rate;
    logic [BPM_W-1:0]         r_rate_num;

    t_queue_status            q_status;
    logic                     q_push;
    logic [INTERVAL_BITS-1:0] q_push_interval;
    logic                     q_pop;
    logic [INTERVAL_BITS-1:0] q_pop_interval;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat_threshold  <= RST_BEAT_THRESHOLD;
            r_holdoff_samples <= RST_HOLDOFF_SAMPLES;
            r_sample_rate     <= RST_SAMPLE_RATE;
            r_min_rate        <= RST_MIN_RATE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_BEAT_THRESHOLD:  r_beat_threshold  <= i_cfg_data[THRESHOLD_W-1:0];
                CFG_HOLDOFF_SAMPLES: r_holdoff_samples <= i_cfg_data[HOLDOFF_W-1:0];
                CFG_SAMPLE_RATE:     r_sample_rate     <= i_cfg_data[RATE_W-1:0];
                CFG_MIN_RATE:        r_min_rate        <= i_cfg_data[MIN_RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // samples per minute, at most 61380
    always_ff @(posedge i_clk) begin
        r_rate_num <= BPM_W'(r_sample_rate * SECONDS_PER_MINUTE);
    end

    bird_front #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .INTERVAL_BITS (INTERVAL_BITS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_filtered_sample (i_filtered_sample),
        .i_beat_threshold  (r_beat_threshold),
        .i_holdoff_samples (r_holdoff_samples),
        .i_min_rate        (r_min_rate),
        .i_rate_num        (r_rate_num),
        .i_q_status        (q_status),
        .o_push            (q_push),
        .o_push_interval   (q_push_interval)
    );

    bird_queue #(
        .WIDTH (INTERVAL_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_interval),
        .i_pop       (q_pop),
        .o_pop_data  (q_pop_interval),
        .o_status    (q_status)
    );

    bird_back #(
        .INTERVAL_BITS (INTERVAL_BITS)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_rate_num         (r_rate_num),
        .i_q_status         (q_status),
        .i_q_interval       (q_pop_interval),
        .o_pop              (q_pop),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_beats_per_minute (o_beats_per_minute)
    );

endmodule

>>> tb/sv/tb_beat_interval_rate_detector.sv
// ----------------------------------------------------------------------------
// tb_beat_interval_rate_detector
// self-checking bench: samples go in through a gapped driver, every accepted
// item steps a local beat/rate predictor, rates out are matched in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_beat_interval_rate_detector;
    import bird_pkg::*;

    localparam int SW            = DEF_SAMPLE_BITS;
    localparam int IW            = DEF_INTERVAL_BITS;
    localparam int SETTLE_CYCLES = 64;
    localparam int MAX_SHOWN     = 10;
    localparam int RANDOM_ITEMS  = 950;

    // indexes past the register list, writes there must be dropped
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_FIRST = CFG_INDEX_W'(4);
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LAST  = '1;

    localparam logic [THRESHOLD_W-1:0] THRESHOLD_MAX = '1;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic signed [SW-1:0]    i_filtered_sample;
    logic                    o_valid;
    logic                    i_stall;
    logic [BPM_W-1:0]        o_beats_per_minute;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_INDEX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;

    beat_interval_rate_detector dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_filtered_sample  (i_filtered_sample),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_beats_per_minute (o_beats_per_minute),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    // register copies and detector state
    logic [THRESHOLD_W-1:0]  cur_threshold;
    logic [HOLDOFF_W-1:0]    cur_holdoff;
    logic [RATE_W-1:0]       cur_rate;
    logic [MIN_RATE_W-1:0]   cur_min_rate;
    logic [HOLDOFF_W-1:0]    holdoff_left;
    logic [IW-1:0]           interval_len;

    logic signed [SW-1:0]    samples_pending[$];
    logic [BPM_W-1:0]        bpm_expected[$];

    int  err_count       = 0;
    int  items_queued    = 0;
    int  gap_left        = 0;
    int  stall_left      = 0;
    bit  src_pause_en    = 1'b1;
    bit  snk_pause_en    = 1'b1;
    bit  sample_taken    = 1'b0;
    bit  rate_taken      = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_error(input string msg);
        if (err_count < MAX_SHOWN) begin
            $display("%0t: %s", $realtime, msg);
        end
        err_count++;
    endtask

    task automatic predict_beat_rate(input logic signed [SW-1:0] smp);
        logic [SW:0]        mag;
        logic [2*SW+1:0]    sq;
        logic [BPM_W-1:0]   num;
        logic [31:0]        bound;
        mag = smp[SW-1] ? -{1'b1, smp} : {1'b0, smp};
        sq  = mag * mag;
        if (sq > cur_threshold) begin
            if (holdoff_left == 0) begin
                if (interval_len != 0) begin
                    num   = BPM_W'(cur_rate) * BPM_W'(SECONDS_PER_MINUTE);
                    bound = 32'(cur_min_rate) * 32'(interval_len);
                    if (32'(num) > bound) begin
                        bpm_expected = {bpm_expected, BPM_W'(num / interval_len)};
                    end
                end
                interval_len = 1;
            end
            holdoff_left = cur_holdoff;
        end else if (holdoff_left != 0) begin
            holdoff_left--;
        end
        if (interval_len != '1) begin
            interval_len++;
        end
    endtask

    // sample driver
    always @(negedge i_clk) begin
        if (!(i_valid && !sample_taken)) begin
            if (samples_pending.size() == 0) begin
                i_valid <= 1'b0;
            end else if (gap_left != 0) begin
                i_valid <= 1'b0;
                gap_left--;
            end else begin
                i_filtered_sample <= samples_pending.pop_front();
                i_valid           <= 1'b1;
                gap_left = src_pause_en ? $urandom_range(0, 16) : 0;
            end
        end
    end

    // rate sink, the wait only runs down while a rate is offered
    always @(negedge i_clk) begin
        if (rate_taken) begin
            stall_left = snk_pause_en ? $urandom_range(0, 16) : 0;
        end else if (o_valid && stall_left != 0) begin
            stall_left--;
        end
        i_stall <= (stall_left != 0);
    end

    // monitor: register copies, prediction and rate checks
    always @(posedge i_clk) begin
        logic [BPM_W-1:0] want;
        sample_taken <= i_rst_n && i_valid && !o_stall;
        rate_taken   <= i_rst_n && o_valid && !i_stall;
        if (!i_rst_n) begin
            cur_threshold = RST_BEAT_THRESHOLD;
            cur_holdoff   = RST_HOLDOFF_SAMPLES;
            cur_rate      = RST_SAMPLE_RATE;
            cur_min_rate  = RST_MIN_RATE;
            holdoff_left  = '0;
            interval_len  = '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BEAT_THRESHOLD:  cur_threshold = i_cfg_data[THRESHOLD_W-1:0];
                    CFG_HOLDOFF_SAMPLES: cur_holdoff   = i_cfg_data[HOLDOFF_W-1:0];
                    CFG_SAMPLE_RATE:     cur_rate      = i_cfg_data[RATE_W-1:0];
                    CFG_MIN_RATE:        cur_min_rate  = i_cfg_data[MIN_RATE_W-1:0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                predict_beat_rate(i_filtered_sample);
            end
            if (o_valid && !i_stall) begin
                if (bpm_expected.size() == 0) begin
                    report_error($sformatf("unexpected rate %0d", o_beats_per_minute));
                end else begin
                    want = bpm_expected.pop_front();
                    if (o_beats_per_minute !== want) begin
                        report_error($sformatf("rate mismatch: expected %0d, got %0d",
                                               want, o_beats_per_minute));
                    end
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_registers(input logic [THRESHOLD_W-1:0] thr,
                                 input logic [HOLDOFF_W-1:0] hold,
                                 input logic [RATE_W-1:0] rate,
                                 input logic [MIN_RATE_W-1:0] min_r);
        // junk in the unused upper data bits
        write_reg(CFG_BEAT_THRESHOLD, thr);
        write_reg(CFG_HOLDOFF_SAMPLES, {(CFG_DATA_W-HOLDOFF_W)'($urandom), hold});
        write_reg(CFG_SAMPLE_RATE, {(CFG_DATA_W-RATE_W)'($urandom), rate});
        write_reg(CFG_MIN_RATE, {(CFG_DATA_W-MIN_RATE_W)'($urandom), min_r});
    endtask

    task automatic wait_drained();
        while (samples_pending.size() != 0 || i_valid || bpm_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_sample(input logic signed [SW-1:0] smp);
        samples_pending = {samples_pending, smp};
        items_queued++;
    endtask

    function automatic logic signed [SW-1:0] loud_sample();
        int mag;
        mag = $urandom_range(8000, 32767);
        return $urandom_range(0, 1) ? SW'(-mag) : SW'(mag);
    endfunction

    function automatic logic signed [SW-1:0] quiet_sample();
        int v;
        v = int'($urandom_range(0, 200)) - 100;
        return SW'(v);
    endfunction

    // beats with random spacing around the holdoff, plus noise and loud bursts
    task automatic queue_beat_train(input int count);
        int n;
        int k;
        int kind;
        n = 0;
        while (n < count) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                queue_sample(loud_sample());
                k = (kind == 0) ? $urandom_range(0, cur_holdoff)
                                : $urandom_range(cur_holdoff, cur_holdoff + 24);
                repeat (k) queue_sample(quiet_sample());
                n += k + 1;
            end else if (kind < 9) begin
                k = $urandom_range(1, 8);
                repeat (k) queue_sample(SW'($urandom));
                n += k;
            end else begin
                k = $urandom_range(2, 5);
                repeat (k) queue_sample(loud_sample());
                n += k;
            end
        end
    endtask

    initial begin
        int item_base;
        int phase;
        logic [THRESHOLD_W-1:0] thr;
        logic [HOLDOFF_W-1:0]   hold;
        logic [RATE_W-1:0]      rate;
        logic [MIN_RATE_W-1:0]  min_r;

        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_stall           = 1'b0;
        i_filtered_sample = '0;
        i_cfg_valid       = 1'b0;
        i_cfg_index       = '0;
        i_cfg_data        = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: beat on an empty interval, most negative sample,
        // over-threshold samples inside the holdoff
        queue_sample(SW'(-32768));
        queue_sample(SW'(32767));
        queue_sample(SW'(0));
        queue_sample(SW'(17));
        queue_sample(SW'(18));
        wait_drained();

        set_registers('0, '0, RATE_W'(1000), '0);
        write_reg(CFG_SPARE_FIRST, CFG_DATA_W'($urandom));
        write_reg(CFG_SPARE_LAST, CFG_DATA_W'($urandom));
        queue_sample(SW'(1));
        queue_sample(SW'(1));
        queue_sample(SW'(-1));
        queue_sample(SW'(0));
        queue_sample(SW'(-1));
        wait_drained();

        // zero sample rate never yields a rate
        write_reg(CFG_SAMPLE_RATE, '0);
        queue_sample(SW'(-1));
        queue_sample(SW'(-1));
        wait_drained();

        // rate equal to the minimum is dropped, and so is one below it
        write_reg(CFG_SAMPLE_RATE, CFG_DATA_W'(1));
        write_reg(CFG_MIN_RATE, CFG_DATA_W'(30));
        queue_sample(SW'(-1));
        queue_sample(SW'(0));
        queue_sample(SW'(-1));
        queue_sample(SW'(-1));
        wait_drained();

        set_registers(THRESHOLD_MAX, '1, RATE_W'(1), '1);
        queue_sample(SW'(-32767));
        queue_sample(SW'(-32768));
        queue_sample(SW'(-32768));
        wait_drained();

        item_base = items_queued;
        for (phase = 0; phase < 40; phase++) begin
            if (items_queued - item_base >= RANDOM_ITEMS) begin
                break;
            end
            thr   = ($urandom_range(0, 7) == 0) ? THRESHOLD_W'($urandom)
                  : ($urandom_range(0, 7) == 0) ? '0
                  : THRESHOLD_W'($urandom_range(10000, 60000000));
            hold  = ($urandom_range(0, 7) == 0) ? '1 : HOLDOFF_W'($urandom_range(0, 12));
            rate  = ($urandom_range(0, 7) == 0) ? RATE_W'($urandom)
                  : RATE_W'($urandom_range(200, 1000));
            min_r = ($urandom_range(0, 7) == 0) ? MIN_RATE_W'($urandom)
                  : MIN_RATE_W'($urandom_range(0, 40));
            set_registers(thr, hold, rate, min_r);
            src_pause_en = ($urandom_range(0, 3) != 0);
            snk_pause_en = ($urandom_range(0, 3) != 0);
            queue_beat_train(160);
            wait_drained();
        end

        if (bpm_expected.size() != 0) begin
            report_error($sformatf("%0d rates never arrived", bpm_expected.size()));
        end
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
